// ===== sv/mpc_pkg.sv =====
// Shared definitions for the magic prefix classifier.
// Holds the opcode type and the command/status structs between controller and datapath.
// No dependencies.
package mpc_pkg;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_SIG_BYTE = 2'd1,
        OP_BUF_BYTE = 2'd2,
        OP_END_BUF  = 2'd3
    } op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic apply;        // perform a clear, signature byte or buffer byte item
        logic search_init;  // start a search at entry 0, byte 0
        logic next_entry;   // move to the next entry, byte 0
        logic next_byte;    // move to the next byte of the current entry
        logic finish_hit;   // report the current entry as matched
        logic finish_miss;  // report no match
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic count_zero;   // table is empty
        logic entry_last;   // current entry is the last committed one
        logic len_over;     // current signature is longer than the buffer
        logic byte_eq;      // current signature byte equals header byte
        logic byte_last;    // current byte is the last of the signature
    } status_t;

endpackage

// ===== sv/mpc_datapath.sv =====
// Datapath of the magic prefix classifier: signature table, header buffer,
// search pointers and the result register. Uses mpc_pkg.
module mpc_datapath #(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_SIG_LEN = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       op,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  mpc_pkg::cmd_t    cmd,
    output mpc_pkg::status_t status,
    output logic             done,
    output logic             found,
    output logic [5:0]       entry_index,
    output logic [6:0]       entry_count,
    output logic             overflow
);

    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int EW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LW    = $clog2(MAX_SIG_LEN + 1);
    localparam int IW    = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;
    localparam int DEPTH = MAX_ENTRIES * MAX_SIG_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Storage
    logic [7:0]    store_mem [DEPTH];
    logic [LW-1:0] len_mem   [MAX_ENTRIES];
    logic [7:0]    hdr_mem   [MAX_SIG_LEN];

    // Control state
    logic [CW-1:0] count_reg, count_next;
    logic [LW-1:0] pend_len_reg, pend_len_next;
    logic          pend_drop_reg, pend_drop_next;
    logic          ovf_reg, ovf_next;
    logic [LW-1:0] hdr_len_reg, hdr_len_next;
    logic          done_reg;

    // Search pointers and read data
    logic [EW-1:0] entry_reg;
    logic [IW-1:0] byte_reg;
    logic [LW-1:0] len_q;
    logic [7:0]    store_q;
    logic [7:0]    hdr_q;

    // Result payload
    logic          found_reg;
    logic [5:0]    idx_reg;
    logic [6:0]    cnt_reg;

    // Write controls
    logic          is_sig;
    logic          sig_full;
    logic          sig_long;
    logic          drop_eff;
    logic          store_we;
    logic [LW-1:0] pend_eff;
    logic          len_we;
    logic          hdr_we;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          finish;

    assign finish = cmd.finish_hit | cmd.finish_miss;
    assign is_sig = cmd.apply && (op == mpc_pkg::OP_SIG_BYTE);

    // Signature byte handling
    assign sig_full = (count_reg >= CW'(MAX_ENTRIES));
    assign sig_long = (pend_len_reg >= LW'(MAX_SIG_LEN));
    assign drop_eff = pend_drop_reg | sig_full | sig_long;
    assign store_we = is_sig && !drop_eff;
    assign pend_eff = store_we ? LW'(pend_len_reg + 1'b1) : pend_len_reg;
    assign len_we   = is_sig && last_byte && !drop_eff && (pend_eff != '0);
    assign hdr_we   = cmd.apply && (op == mpc_pkg::OP_BUF_BYTE)
                      && (hdr_len_reg < LW'(MAX_SIG_LEN));

    assign wr_addr = AW'(count_reg[EW-1:0]) * AW'(MAX_SIG_LEN) + AW'(pend_len_reg[IW-1:0]);
    assign rd_addr = AW'(entry_reg) * AW'(MAX_SIG_LEN) + AW'(byte_reg);

    // Next state of table and buffer
    always_comb
    begin
        count_next     = count_reg;
        pend_len_next  = pend_len_reg;
        pend_drop_next = pend_drop_reg;
        ovf_next       = ovf_reg;
        hdr_len_next   = hdr_len_reg;
        if (cmd.apply)
        begin
            case (op)
                mpc_pkg::OP_CLEAR:
                begin
                    count_next     = '0;
                    pend_len_next  = '0;
                    pend_drop_next = 1'b0;
                    ovf_next       = 1'b0;
                end
                mpc_pkg::OP_SIG_BYTE:
                begin
                    if (last_byte)
                    begin
                        if (len_we)
                            count_next = CW'(count_reg + 1'b1);
                        else
                            ovf_next = 1'b1;
                        pend_len_next  = '0;
                        pend_drop_next = 1'b0;
                    end
                    else
                    begin
                        pend_len_next  = pend_eff;
                        pend_drop_next = drop_eff;
                    end
                end
                mpc_pkg::OP_BUF_BYTE:
                begin
                    if (hdr_we)
                        hdr_len_next = LW'(hdr_len_reg + 1'b1);
                end
                default:
                begin
                    hdr_len_next = hdr_len_reg;
                end
            endcase
        end
        // a finished search starts a new empty buffer
        if (finish)
            hdr_len_next = '0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_len_reg  <= '0;
            pend_drop_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            hdr_len_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_len_reg  <= pend_len_next;
            pend_drop_reg <= pend_drop_next;
            ovf_reg       <= ovf_next;
            hdr_len_reg   <= hdr_len_next;
            done_reg      <= finish;
        end
    end

    // Search pointers and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.search_init)
        begin
            entry_reg <= '0;
            byte_reg  <= '0;
        end
        else if (cmd.next_entry)
        begin
            entry_reg <= EW'(entry_reg + 1'b1);
            byte_reg  <= '0;
        end
        else if (cmd.next_byte)
        begin
            byte_reg <= IW'(byte_reg + 1'b1);
        end
        if (finish)
        begin
            found_reg <= cmd.finish_hit;
            idx_reg   <= cmd.finish_hit ? 6'(entry_reg) : 6'd0;
            cnt_reg   <= 7'(count_reg);
        end
    end

    // Signature byte store
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[wr_addr] <= data_byte;
        store_q <= store_mem[rd_addr];
    end

    // Signature length store
    always_ff @(posedge clk)
    begin
        if (len_we)
            len_mem[count_reg[EW-1:0]] <= pend_eff;
        len_q <= len_mem[entry_reg];
    end

    // Header byte buffer
    always_ff @(posedge clk)
    begin
        if (hdr_we)
            hdr_mem[hdr_len_reg[IW-1:0]] <= data_byte;
        hdr_q <= hdr_mem[byte_reg];
    end

    // Status to controller
    assign status.count_zero = (count_reg == '0);
    assign status.entry_last = (CW'(CW'(entry_reg) + 1'b1) == count_reg);
    assign status.len_over   = (len_q > hdr_len_reg);
    assign status.byte_eq    = (store_q == hdr_q);
    assign status.byte_last  = (LW'(LW'(byte_reg) + 1'b1) == len_q);

    assign done        = done_reg;
    assign found       = found_reg;
    assign entry_index = idx_reg;
    assign entry_count = cnt_reg;
    assign overflow    = ovf_reg;

endmodule

// ===== sv/mpc_controller.sv =====
// Controller of the magic prefix classifier: accepts items and sequences the
// entry-by-entry search. Uses mpc_pkg.
module mpc_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       op,
    input  mpc_pkg::status_t status,
    output mpc_pkg::cmd_t    cmd,
    output logic             busy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN_WAIT,
        ST_LEN_CHK,
        ST_BYTE_WAIT,
        ST_BYTE_CHK
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;
    logic   accept;

    assign accept = start && !busy_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == mpc_pkg::OP_END_BUF)
                    begin
                        cmd.search_init = 1'b1;
                        if (status.count_zero)
                            cmd.finish_miss = 1'b1;
                        else
                            state_next = ST_LEN_WAIT;
                    end
                    else
                    begin
                        cmd.apply = 1'b1;
                    end
                end
            end
            ST_LEN_WAIT:
            begin
                state_next = ST_LEN_CHK;
            end
            ST_LEN_CHK:
            begin
                // byte 0 data is already read alongside the length
                if (!status.len_over)
                    state_next = ST_BYTE_CHK;
                else if (status.entry_last)
                begin
                    cmd.finish_miss = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.next_entry = 1'b1;
                    state_next     = ST_LEN_WAIT;
                end
            end
            ST_BYTE_WAIT:
            begin
                state_next = ST_BYTE_CHK;
            end
            ST_BYTE_CHK:
            begin
                if (!status.byte_eq)
                begin
                    if (status.entry_last)
                    begin
                        cmd.finish_miss = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_entry = 1'b1;
                        state_next     = ST_LEN_WAIT;
                    end
                end
                else if (status.byte_last)
                begin
                    cmd.finish_hit = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.next_byte = 1'b1;
                    state_next    = ST_BYTE_WAIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

// ===== sv/magic_prefix_classifier_unit.sv =====
// Magic prefix classifier: clear, signature byte and buffer byte transactions keep
// busy low. An end-of-buffer transaction walks the table in load order: each entry
// passes ST_LEN_WAIT and ST_LEN_CHK, its first byte is compared in ST_BYTE_CHK and each
// further byte passes ST_BYTE_WAIT and ST_BYTE_CHK; done pulses in the cycle after the
// decision (after accept for an empty table). The receiver cannot stall the done strobe.
// Reset is asynchronous active low: table empty, flags clear; no clearing pass.
module magic_prefix_classifier_unit #(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_SIG_LEN = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] op,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       done,
    output logic       found,
    output logic [5:0] entry_index,
    output logic [6:0] entry_count,
    output logic       overflow
);

    mpc_pkg::cmd_t    cmd;
    mpc_pkg::status_t status;

    // Sequencer
    mpc_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Table, buffer and result
    mpc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_SIG_LEN (MAX_SIG_LEN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .cmd         (cmd),
        .status      (status),
        .done        (done),
        .found       (found),
        .entry_index (entry_index),
        .entry_count (entry_count),
        .overflow    (overflow)
    );

endmodule

// ===== verif/magic_prefix_classifier_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the magic prefix classifier: signature loading, buffer
// gathering and end-of-buffer searches, checked against an in-bench table predictor.
// Depends on mpc_pkg and magic_prefix_classifier_unit.
module magic_prefix_classifier_unit_tb;

    localparam int NUM_ENTRIES = 64;
    localparam int SIG_BYTES   = 16;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        mpc_pkg::op_t op;
        logic [7:0]   data;
        logic         last;
    } mpc_item_t;

    typedef struct packed {
        logic       found;
        logic [5:0] idx;
        logic [6:0] count;
        logic       ovf;
    } match_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    mpc_pkg::op_t op = mpc_pkg::OP_CLEAR;
    logic [7:0]   data_byte = 8'd0;
    logic         last_byte = 1'b0;
    logic         busy;
    logic         done;
    logic         found;
    logic [5:0]   entry_index;
    logic [6:0]   entry_count;
    logic         overflow;

    magic_prefix_classifier_unit #(
        .MAX_ENTRIES(NUM_ENTRIES),
        .MAX_SIG_LEN(SIG_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .done(done),
        .found(found),
        .entry_index(entry_index),
        .entry_count(entry_count),
        .overflow(overflow)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mpc_item_t     queued_items[$];
    match_result_t predicted_matches[$];
    int            total_items;
    int            presented_items = 0;
    int            accepted_items = 0;
    int            error_count = 0;
    int            cycle_count = 0;

    // Predicted table state
    logic [7:0] sig_mem [NUM_ENTRIES][SIG_BYTES];
    int         sig_len [NUM_ENTRIES];
    int         tbl_count = 0;
    int         pend_len = 0;
    logic       pend_drop = 1'b0;
    logic       sticky_ovf = 1'b0;
    logic [7:0] hdr [SIG_BYTES];
    int         hdr_len = 0;

    // Stimulus-side view of committed signatures, used to aim probes at real entries
    logic [7:0] g_bytes [NUM_ENTRIES][SIG_BYTES];
    int         g_len [NUM_ENTRIES];
    int         g_n = 0;

    // First entry in load order that fits within and equals the header bytes
    function automatic match_result_t table_search();
        match_result_t r;
        int            e;
        int            i;
        logic          hit;
        r = '0;
        r.count = 7'(tbl_count);
        r.ovf = sticky_ovf;
        for (e = 0; e < tbl_count; e++)
        begin
            hit = (sig_len[e] <= hdr_len);
            for (i = 0; hit && i < sig_len[e]; i++)
                if (sig_mem[e][i] != hdr[i])
                    hit = 1'b0;
            if (hit)
            begin
                r.found = 1'b1;
                r.idx = 6'(e);
                break;
            end
        end
        return r;
    endfunction

    // Update the predicted table for one accepted transaction
    task automatic table_apply(mpc_pkg::op_t o, logic [7:0] b, logic l);
        case (o)
            mpc_pkg::OP_CLEAR:
            begin
                tbl_count = 0;
                pend_len = 0;
                pend_drop = 1'b0;
                sticky_ovf = 1'b0;
            end
            mpc_pkg::OP_SIG_BYTE:
            begin
                if (tbl_count >= NUM_ENTRIES || pend_len >= SIG_BYTES)
                    pend_drop = 1'b1;
                else if (!pend_drop)
                begin
                    sig_mem[tbl_count][pend_len] = b;
                    pend_len++;
                end
                if (l)
                begin
                    if (pend_drop || pend_len == 0)
                        sticky_ovf = 1'b1;
                    else
                    begin
                        sig_len[tbl_count] = pend_len;
                        tbl_count++;
                    end
                    pend_len = 0;
                    pend_drop = 1'b0;
                end
            end
            mpc_pkg::OP_BUF_BYTE:
            begin
                if (hdr_len < SIG_BYTES)
                begin
                    hdr[hdr_len] = b;
                    hdr_len++;
                end
            end
            default:
            begin
                predicted_matches = {predicted_matches, table_search()};
                hdr_len = 0;
            end
        endcase
    endtask

    task automatic push_item(mpc_pkg::op_t o, logic [7:0] b, logic l);
        mpc_item_t it;
        it.op = o;
        it.data = b;
        it.last = l;
        queued_items = {queued_items, it};
    endtask

    // last_byte is a don't-care outside signature bytes, so toggle it
    task automatic push_plain(mpc_pkg::op_t o, logic [7:0] b);
        push_item(o, b, 1'($urandom_range(0, 1)));
    endtask

    task automatic push_clear();
        push_plain(mpc_pkg::OP_CLEAR, 8'($urandom));
        g_n = 0;
    endtask

    // Signature of len bytes, optionally sharing a prefix with a committed entry
    task automatic gen_signature(int len, logic share);
        logic [7:0] sb [32];
        int         src;
        int         i;
        src = -1;
        if (share && g_n > 0)
            src = $urandom_range(0, g_n - 1);
        for (i = 0; i < len; i++)
        begin
            if (src >= 0 && i < g_len[src] && $urandom_range(0, 3) != 0)
                sb[i] = g_bytes[src][i];
            else
                sb[i] = 8'($urandom);
            push_item(mpc_pkg::OP_SIG_BYTE, sb[i], i == len - 1);
        end
        if (len <= SIG_BYTES && g_n < NUM_ENTRIES)
        begin
            for (i = 0; i < len; i++)
                g_bytes[g_n][i] = sb[i];
            g_len[g_n] = len;
            g_n++;
        end
    endtask

    // Buffer bytes then end of buffer; mostly aimed at a committed entry
    task automatic gen_probe(int target);
        int         e;
        int         n;
        int         i;
        int         flip;
        logic [7:0] v;
        if (g_n > 0 && (target >= 0 || $urandom_range(0, 99) < 65))
        begin
            e = (target >= 0) ? target : $urandom_range(0, g_n - 1);
            n = g_len[e] + $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0)
                n = g_len[e] - 1;
            flip = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n) : -1;
            for (i = 0; i < n; i++)
            begin
                v = (i < g_len[e]) ? g_bytes[e][i] : 8'($urandom);
                if (i == flip)
                    v ^= 8'(1) << $urandom_range(0, 7);
                push_plain(mpc_pkg::OP_BUF_BYTE, v);
            end
        end
        else
        begin
            n = $urandom_range(0, SIG_BYTES + 3);
            for (i = 0; i < n; i++)
                push_plain(mpc_pkg::OP_BUF_BYTE, 8'($urandom));
        end
        push_plain(mpc_pkg::OP_END_BUF, 8'($urandom));
    endtask

    // Odd items: lone searches, stray bytes, broken signatures
    task automatic gen_noise();
        int k;
        int i;
        case ($urandom_range(0, 3))
            0: push_plain(mpc_pkg::OP_END_BUF, 8'($urandom));
            1: push_plain(mpc_pkg::OP_BUF_BYTE, 8'($urandom));
            2: gen_signature(1, 1'b0);
            default:
            begin
                k = $urandom_range(1, 4);
                for (i = 0; i < k; i++)
                    push_item(mpc_pkg::OP_SIG_BYTE, 8'($urandom), 1'b0);
                push_clear();
            end
        endcase
    endtask

    task automatic gen_mixed(int upto);
        int pick;
        while (queued_items.size() < upto)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                if ($urandom_range(0, 99) < 8)
                    gen_signature($urandom_range(SIG_BYTES + 1, SIG_BYTES + 3), 1'b0);
                else if ($urandom_range(0, 9) == 0)
                    gen_signature($urandom_range(7, SIG_BYTES), 1'b1);
                else
                    gen_signature($urandom_range(1, 6), 1'b1);
            end
            else if (pick < 85)
                gen_probe(-1);
            else if (pick < 88)
                push_clear();
            else
                gen_noise();
        end
    endtask

    // Driver: present queued transactions, hold while busy, idle at random
    always @(posedge clk)
    begin : drive_proc
        mpc_item_t nxt;
        logic      pause;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                table_apply(op, data_byte, last_byte);
                accepted_items++;
            end
            if (!start || !busy)
            begin
                pause = ($urandom_range(0, 99) < 23) &&
                        !(presented_items >= 200 && presented_items < 320);
                if (pause || queued_items.size() == 0)
                    start <= 1'b0;
                else
                begin
                    nxt = queued_items.pop_front();
                    op <= nxt.op;
                    data_byte <= nxt.data;
                    last_byte <= nxt.last;
                    start <= 1'b1;
                    presented_items++;
                end
            end
        end
    end

    task automatic check_field(string fname, int want, int got);
        if (want != got)
        begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, fname, want, got);
            error_count++;
        end
    endtask

    // Monitor: every done strobe is checked against the oldest prediction
    always @(posedge clk)
    begin : monitor_proc
        match_result_t want;
        if (rst_n && done)
        begin
            if (predicted_matches.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %s%0d %s%0d %s%0d %s%0d",
                         $time, "found=", found, "index=", entry_index,
                         "count=", entry_count, "overflow=", overflow);
                error_count++;
            end
            else
            begin
                want = predicted_matches.pop_front();
                check_field("found", want.found, found);
                check_field("entry_index", want.idx, entry_index);
                check_field("entry_count", want.count, entry_count);
                check_field("overflow", want.ovf, overflow);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     predicted_matches.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int  k;
        int  salt;
        // Directed: empty table and empty buffer, ignored fields set high
        push_item(mpc_pkg::OP_END_BUF, 8'hFF, 1'b1);
        // Entry 0 = A5 5A, entry 1 = 00
        push_item(mpc_pkg::OP_SIG_BYTE, 8'hA5, 1'b0);
        push_item(mpc_pkg::OP_SIG_BYTE, 8'h5A, 1'b1);
        push_item(mpc_pkg::OP_SIG_BYTE, 8'h00, 1'b1);
        g_bytes[0][0] = 8'hA5;
        g_bytes[0][1] = 8'h5A;
        g_len[0] = 2;
        g_bytes[1][0] = 8'h00;
        g_len[1] = 1;
        g_n = 2;
        // Buffer shorter than entry 0: entry 1 hits
        push_item(mpc_pkg::OP_BUF_BYTE, 8'h00, 1'b1);
        push_item(mpc_pkg::OP_END_BUF, 8'h00, 1'b0);
        // Buffer longer than entry 0: entry 0 hits
        push_item(mpc_pkg::OP_BUF_BYTE, 8'hA5, 1'b0);
        push_item(mpc_pkg::OP_BUF_BYTE, 8'h5A, 1'b1);
        push_item(mpc_pkg::OP_BUF_BYTE, 8'h77, 1'b0);
        push_item(mpc_pkg::OP_END_BUF, 8'h12, 1'b1);
        // Miss, then empty buffer right after a search
        push_item(mpc_pkg::OP_BUF_BYTE, 8'hFF, 1'b1);
        push_item(mpc_pkg::OP_END_BUF, 8'hFF, 1'b0);
        push_item(mpc_pkg::OP_END_BUF, 8'h00, 1'b0);
        // Header bytes survive a clear, which also drops a partly loaded signature
        push_item(mpc_pkg::OP_SIG_BYTE, 8'h3C, 1'b0);
        push_item(mpc_pkg::OP_BUF_BYTE, 8'hFF, 1'b0);
        push_item(mpc_pkg::OP_CLEAR, 8'hFF, 1'b1);
        push_item(mpc_pkg::OP_SIG_BYTE, 8'hFF, 1'b1);
        push_item(mpc_pkg::OP_END_BUF, 8'h00, 1'b1);
        g_bytes[0][0] = 8'hFF;
        g_len[0] = 1;
        g_n = 1;

        // Mixed traffic
        gen_mixed(180);

        // Fill the table with unique short entries, then overrun it
        push_clear();
        salt = $urandom_range(0, 255);
        for (k = 0; k < NUM_ENTRIES; k++)
        begin
            g_bytes[k][0] = 8'(salt + k);
            g_len[k] = 1;
            if ($urandom_range(0, 3) == 0)
            begin
                g_bytes[k][1] = 8'($urandom);
                g_len[k] = 2;
                push_item(mpc_pkg::OP_SIG_BYTE, g_bytes[k][0], 1'b0);
            end
            push_item(mpc_pkg::OP_SIG_BYTE, g_bytes[k][g_len[k] - 1], 1'b1);
        end
        g_n = NUM_ENTRIES;
        gen_probe(NUM_ENTRIES - 1);
        // Table full: dropped entry sets overflow
        push_item(mpc_pkg::OP_SIG_BYTE, 8'($urandom), 1'b1);
        gen_probe(NUM_ENTRIES - 1);
        gen_probe(0);
        for (k = 0; k < 4; k++)
            gen_probe(-1);
        gen_signature(3, 1'b0);
        gen_probe(-1);

        // Longest signature and a buffer that runs past it
        push_clear();
        gen_signature(SIG_BYTES, 1'b0);
        gen_probe(0);
        gen_signature(SIG_BYTES + 1, 1'b0);
        gen_probe(-1);
        gen_mixed(420);

        total_items = queued_items.size();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_items < total_items)
            @(posedge clk);
        while (predicted_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
